>>> design/i2crw_pkg.sv
// ---------------------------------------------------------------------------
// i2crw_pkg
// Shared types, codes and constants of the I2C register writer: item codes,
// bus phase encoding, status codes, queue word layout and the codec defaults.
// ---------------------------------------------------------------------------
package i2crw_pkg;

    // Field widths
    localparam int IDX_W     = 6;
    localparam int VAL_W     = 9;
    localparam int PT_W      = 16;
    localparam int DEV_W     = 8;
    localparam int STAT_W    = 2;
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int BITC_W    = 4;
    localparam int BYTEC_W   = 2;

    // Register file size and configuration reset values
    localparam int                NUM_REGS_DEFAULT  = 56;
    localparam logic [PT_W-1:0]   PHASE_TICKS_RESET = 16'd5;
    localparam logic [DEV_W-1:0]  DEV_ADDR_RESET    = 8'h34;
    localparam logic [BITC_W-1:0] BITS_PER_BYTE     = 4'd8;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHASE_TICKS = 2'd0,
        CFG_DEV_ADDR    = 2'd1
    } cfg_reg_t;

    // Item codes
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2
    } cmd_code_t;

    // Transfer status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_ADDR_NACK = 2'd1,
        STAT_DATA_NACK = 2'd2
    } status_t;

    // Bus phases
    typedef enum logic [4:0] {
        PH_IDLE    = 5'd0,
        PH_START_A = 5'd1,
        PH_START_B = 5'd2,
        PH_START_C = 5'd3,
        PH_BIT_0   = 5'd4,
        PH_BIT_1   = 5'd5,
        PH_BIT_2   = 5'd6,
        PH_BIT_3   = 5'd7,
        PH_ACK_0   = 5'd8,
        PH_ACK_1   = 5'd9,
        PH_ACK_2   = 5'd10,
        PH_ACK_3   = 5'd11,
        PH_STOP_A  = 5'd12,
        PH_STOP_B  = 5'd13,
        PH_STOP_C  = 5'd14
    } bus_phase_t;

    // Classified word passed from front to back
    typedef struct packed {
        cmd_code_t        kind;
        logic             in_range;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] value;
        logic             sda_in;
    } queue_word_t;

    // Codec register defaults, entries past the table read as zero
    localparam logic [VAL_W-1:0] CODEC_DEFAULTS [64] = '{
        9'h097, 9'h097, 9'h000, 9'h000, 9'h000, 9'h008, 9'h000, 9'h00A,
        9'h1C0, 9'h000, 9'h0FF, 9'h0FF, 9'h000, 9'h000, 9'h000, 9'h000,
        9'h000, 9'h07B, 9'h100, 9'h032, 9'h000, 9'h0C3, 9'h0C3, 9'h1C0,
        9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000,
        9'h100, 9'h100, 9'h050, 9'h050, 9'h050, 9'h050, 9'h000, 9'h000,
        9'h000, 9'h000, 9'h040, 9'h000, 9'h000, 9'h050, 9'h050, 9'h000,
        9'h000, 9'h037, 9'h04D, 9'h080, 9'h008, 9'h031, 9'h026, 9'h0ED,
        9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000
    };

    function automatic logic [VAL_W-1:0] codec_default(input logic [IDX_W-1:0] idx);
        return CODEC_DEFAULTS[idx];
    endfunction

endpackage

>>> design/i2crw_front.sv
// ---------------------------------------------------------------------------
// i2crw_front
// Accepts input words, classifies the command and index range, and holds
// them in a two-entry queue for the bus sequencer.
// ---------------------------------------------------------------------------
module i2crw_front
    import i2crw_pkg::*;
#(
    parameter int NUM_REGS = NUM_REGS_DEFAULT
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [CMD_W-1:0] s_command,
    input  logic [IDX_W-1:0] s_reg_index,
    input  logic [VAL_W-1:0] s_reg_value,
    input  logic             s_sda_in,
    output logic             q_valid,
    output queue_word_t      q_word,
    input  logic             q_pop
);

    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;

    queue_word_t             slot_reg [QDEPTH];
    logic [QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]         count_reg, count_next;
    queue_word_t             in_word;
    logic                    push;

    // Classify the incoming word; unused command code acts as a tick
    always_comb begin
        unique case (s_command)
            CMD_WRITE: in_word.kind = CMD_WRITE;
            CMD_READ:  in_word.kind = CMD_READ;
            default:   in_word.kind = CMD_TICK;
        endcase
        in_word.in_range = ({1'b0, s_reg_index} < (IDX_W+1)'(NUM_REGS));
        in_word.idx      = s_reg_index;
        in_word.value    = s_reg_value;
        in_word.sda_in   = s_sda_in;
    end

    assign s_ready = (count_reg < (QPTR_W+1)'(QDEPTH));
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != '0);
    assign q_word  = slot_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb begin
        wr_ptr_next = push  ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(q_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the word
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_word;
        end
    end

endmodule

>>> design/i2crw_back.sv
// ---------------------------------------------------------------------------
// i2crw_back
// Bus sequencer and shadow register file. Takes one queued word per cycle
// if not stalled, steps the I2C write sequence one tick, registers its result.
// ---------------------------------------------------------------------------
module i2crw_back
    import i2crw_pkg::*;
#(
    parameter int NUM_REGS = NUM_REGS_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PT_W-1:0]      cfg_data,
    input  logic                 q_valid,
    input  queue_word_t          q_word,
    output logic                 q_pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_scl_out,
    output logic                 m_sda_out,
    output logic                 m_busy_res,
    output logic                 m_done_res,
    output logic [STAT_W-1:0]    m_status,
    output logic [VAL_W-1:0]     m_read_data
);

    localparam int ADDR_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

    // Configuration
    logic [PT_W-1:0]    phase_ticks_reg;
    logic [DEV_W-1:0]   dev_addr_reg;

    // Sequencer state
    bus_phase_t         phase_reg, phase_next, phase_e;
    logic [PT_W-1:0]    timer_reg, timer_next, timer_e;
    logic [BITC_W-1:0]  bitc_reg, bitc_next, bitc_e, bitc_inc;
    logic [BYTEC_W-1:0] bytec_reg, bytec_next, bytec_e, bytec_inc;
    logic [DEV_W-1:0]   shift_reg, shift_next, shift_e;
    logic [IDX_W-1:0]   hidx_reg, hidx_next, hidx_e;
    logic [VAL_W-1:0]   hval_reg, hval_next, hval_e;
    logic [STAT_W-1:0]  status_reg, status_next, status_e;

    // Step outputs
    logic               scl, sda, busy, done, mem_we;
    logic [PT_W:0]      limit, timer_inc;
    logic               advance;

    // Shadow store
    logic [VAL_W-1:0]   shadow_mem [NUM_REGS];
    logic [NUM_REGS-1:0] written_reg;
    logic [ADDR_W-1:0]  raddr, waddr;
    logic               rd_hit;

    // Result word
    logic               m_valid_reg, m_valid_next;
    logic               scl_reg, sda_reg, busy_reg, done_reg;
    logic [STAT_W-1:0]  ostat_reg;
    logic               rd_hit_reg, written_hit_reg;
    logic [VAL_W-1:0]   rdata_reg, dflt_reg;

    // Take a word whenever the result register is free or drains
    assign advance = q_valid && (!m_valid_reg || m_ready);
    assign q_pop   = advance;

    // Hold configuration words
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_ticks_reg <= PHASE_TICKS_RESET;
            dev_addr_reg    <= DEV_ADDR_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_PHASE_TICKS) begin
                phase_ticks_reg <= cfg_data;
            end
            if (cfg_index == CFG_DEV_ADDR) begin
                dev_addr_reg <= cfg_data[DEV_W-1:0];
            end
        end
    end

    // One tick of the bus sequence
    always_comb begin
        phase_e  = phase_reg;
        timer_e  = timer_reg;
        bitc_e   = bitc_reg;
        bytec_e  = bytec_reg;
        shift_e  = shift_reg;
        hidx_e   = hidx_reg;
        hval_e   = hval_reg;
        status_e = status_reg;

        // Launch a transfer on a write while idle
        if (phase_reg == PH_IDLE && q_word.kind == CMD_WRITE) begin
            phase_e  = PH_START_A;
            timer_e  = '0;
            bitc_e   = '0;
            bytec_e  = '0;
            shift_e  = dev_addr_reg;
            hidx_e   = q_word.idx;
            hval_e   = q_word.value;
            status_e = STAT_OK;
        end

        phase_next  = phase_e;
        timer_next  = timer_e;
        bitc_next   = bitc_e;
        bytec_next  = bytec_e;
        shift_next  = shift_e;
        hidx_next   = hidx_e;
        hval_next   = hval_e;
        status_next = status_e;

        scl    = 1'b1;
        sda    = 1'b1;
        busy   = 1'b0;
        done   = 1'b0;
        mem_we = 1'b0;

        limit     = (phase_ticks_reg == '0) ? (PT_W+1)'(1) : {1'b0, phase_ticks_reg};
        timer_inc = {1'b0, timer_e} + (PT_W+1)'(1);
        bitc_inc  = bitc_e + 1'b1;
        bytec_inc = bytec_e + 1'b1;

        if (phase_e != PH_IDLE) begin
            busy = 1'b1;

            // Drive the lines for this phase
            unique case (phase_e)
                PH_START_B: begin scl = 1'b1; sda = 1'b0; end
                PH_START_C: begin scl = 1'b0; sda = 1'b0; end
                PH_BIT_0, PH_BIT_1: begin scl = 1'b0; sda = shift_e[DEV_W-1]; end
                PH_BIT_2, PH_BIT_3: begin scl = 1'b1; sda = shift_e[DEV_W-1]; end
                PH_ACK_0, PH_ACK_1: begin scl = 1'b0; sda = 1'b1; end
                PH_STOP_A: begin scl = 1'b0; sda = 1'b0; end
                PH_STOP_B: begin scl = 1'b1; sda = 1'b0; end
                default:   begin scl = 1'b1; sda = 1'b1; end
            endcase

            if (timer_inc < limit) begin
                timer_next = timer_inc[PT_W-1:0];
            end else begin
                timer_next = '0;
                unique case (phase_e)
                    PH_START_A: phase_next = PH_START_B;
                    PH_START_B: phase_next = PH_START_C;
                    PH_START_C: phase_next = PH_BIT_0;
                    PH_BIT_0:   phase_next = PH_BIT_1;
                    PH_BIT_1:   phase_next = PH_BIT_2;
                    PH_BIT_2:   phase_next = PH_BIT_3;
                    PH_BIT_3: begin
                        shift_next = {shift_e[DEV_W-2:0], 1'b0};
                        bitc_next  = bitc_inc;
                        phase_next = (bitc_inc >= BITS_PER_BYTE) ? PH_ACK_0 : PH_BIT_0;
                    end
                    PH_ACK_0:   phase_next = PH_ACK_1;
                    PH_ACK_1:   phase_next = PH_ACK_2;
                    PH_ACK_2:   phase_next = PH_ACK_3;
                    PH_ACK_3: begin
                        if (q_word.sda_in) begin
                            // Not acknowledged: flag and stop
                            status_next = (bytec_e == '0) ? STAT_ADDR_NACK : STAT_DATA_NACK;
                            phase_next  = PH_STOP_A;
                        end else begin
                            bytec_next = bytec_inc;
                            bitc_next  = '0;
                            if (bytec_inc == 2'd1) begin
                                shift_next = {1'b0, hidx_e, hval_e[VAL_W-1]};
                                phase_next = PH_BIT_0;
                            end else if (bytec_inc == 2'd2) begin
                                shift_next = hval_e[DEV_W-1:0];
                                phase_next = PH_BIT_0;
                            end else begin
                                phase_next = PH_STOP_A;
                            end
                        end
                    end
                    PH_STOP_A:  phase_next = PH_STOP_B;
                    PH_STOP_B:  phase_next = PH_STOP_C;
                    PH_STOP_C: begin
                        mem_we     = (status_e == STAT_OK)
                                     && ({1'b0, hidx_e} < (IDX_W+1)'(NUM_REGS));
                        done       = 1'b1;
                        phase_next = PH_IDLE;
                    end
                    default:    phase_next = PH_IDLE;
                endcase
            end
        end
    end

    // Sequencer state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            timer_reg  <= '0;
            bitc_reg   <= '0;
            bytec_reg  <= '0;
            shift_reg  <= '0;
            hidx_reg   <= '0;
            hval_reg   <= '0;
            status_reg <= STAT_OK;
        end else if (advance) begin
            phase_reg  <= phase_next;
            timer_reg  <= timer_next;
            bitc_reg   <= bitc_next;
            bytec_reg  <= bytec_next;
            shift_reg  <= shift_next;
            hidx_reg   <= hidx_next;
            hval_reg   <= hval_next;
            status_reg <= status_next;
        end
    end

    // Shadow addresses; out-of-range reads use entry zero and return zero
    assign rd_hit = (q_word.kind == CMD_READ) && q_word.in_range;
    assign raddr  = q_word.in_range ? q_word.idx[ADDR_W-1:0] : '0;
    assign waddr  = mem_we ? hidx_e[ADDR_W-1:0] : '0;

    // Shadow array: read before this tick's write
    always_ff @(posedge aclk) begin
        if (advance) begin
            rdata_reg <= shadow_mem[raddr];
            if (mem_we) begin
                shadow_mem[waddr] <= hval_e;
            end
        end
    end

    // Mark entries that hold a written value
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg <= '0;
        end else if (advance && mem_we) begin
            written_reg[waddr] <= 1'b1;
        end
    end

    // Result word register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            scl_reg         <= scl;
            sda_reg         <= sda;
            busy_reg        <= busy;
            done_reg        <= done;
            ostat_reg       <= status_next;
            rd_hit_reg      <= rd_hit;
            written_hit_reg <= written_reg[raddr];
            dflt_reg        <= codec_default(q_word.idx);
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_scl_out   = scl_reg;
    assign m_sda_out   = sda_reg;
    assign m_busy_res  = busy_reg;
    assign m_done_res  = done_reg;
    assign m_status    = ostat_reg;
    assign m_read_data = !rd_hit_reg     ? '0 :
                         written_hit_reg ? rdata_reg : dflt_reg;

endmodule

>>> design/i2c_codec_register_writer.sv
// ---------------------------------------------------------------------------
// i2c_codec_register_writer
// I2C master write sequencer with a shadow copy of the codec registers.
// ---------------------------------------------------------------------------
// Each input word is one bus tick and yields exactly one result word. The
// block sustains one word per clock while the result side is not stalled:
// a two-entry queue takes words while the sequencer steps one tick per cycle,
// and a result is presented the cycle after its word is taken. The shadow
// store is one array, read once and written at most once per tick; it needs no
// clearing pass after reset, since per-entry written flags fall back to the
// codec defaults. A write command while idle starts start/address/index/data/
// stop on the SCL/SDA drives, each phase lasting phase_ticks ticks.
module i2c_codec_register_writer
    import i2crw_pkg::*;
#(
    parameter int NUM_REGS = NUM_REGS_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PT_W-1:0]      cfg_data,
    // Input channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [CMD_W-1:0]     s_command,
    input  logic [IDX_W-1:0]     s_reg_index,
    input  logic [VAL_W-1:0]     s_reg_value,
    input  logic                 s_sda_in,
    // Result channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_scl_out,
    output logic                 m_sda_out,
    output logic                 m_busy_res,
    output logic                 m_done_res,
    output logic [STAT_W-1:0]    m_status,
    output logic [VAL_W-1:0]     m_read_data
);

    logic        q_valid;
    logic        q_pop;
    queue_word_t q_word;

    assign cfg_ready = 1'b1;

    i2crw_front #(
        .NUM_REGS (NUM_REGS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_command   (s_command),
        .s_reg_index (s_reg_index),
        .s_reg_value (s_reg_value),
        .s_sda_in    (s_sda_in),
        .q_valid     (q_valid),
        .q_word      (q_word),
        .q_pop       (q_pop)
    );

    i2crw_back #(
        .NUM_REGS (NUM_REGS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .q_valid     (q_valid),
        .q_word      (q_word),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_scl_out   (m_scl_out),
        .m_sda_out   (m_sda_out),
        .m_busy_res  (m_busy_res),
        .m_done_res  (m_done_res),
        .m_status    (m_status),
        .m_read_data (m_read_data)
    );

    // A finishing tick always belongs to a transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_done_res |-> m_busy_res)
        else $error("done word without busy");

    // Lines are released whenever no transfer is running
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_busy_res |-> m_scl_out && m_sda_out)
        else $error("bus driven outside a transfer");

    // No result word right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word valid after reset");

endmodule

>>> tb/tb_i2c_codec_register_writer.sv
// ---------------------------------------------------------------------------
// tb_i2c_codec_register_writer
// Self-checking bench for the I2C register writer. Every input word is one
// bus tick and yields one result word; a tick-true model of the sequencer
// and its shadow store predicts each result, and a checker compares them in
// order. Directed cases cover the default table, out-of-range reads and
// writes, writes while busy and phase length changes mid-transfer; random
// traffic then runs whole transfers with random ACK/NACK under several
// phase settings and handshake idling patterns.
// ---------------------------------------------------------------------------
module tb_i2c_codec_register_writer;
    import i2crw_pkg::*;

    localparam int               SHADOW_DEPTH   = NUM_REGS_DEFAULT;
    localparam int               WATCHDOG_LIMIT = 1000;
    localparam int               PRINT_LIMIT    = 40;
    localparam logic [CMD_W-1:0] CMD_UNUSED     = 2'd3;

    // One expected result word
    typedef struct packed {
        logic             scl;
        logic             sda;
        logic             busy;
        logic             done;
        status_t          status;
        logic [VAL_W-1:0] rdata;
    } bus_tick_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [PT_W-1:0]      cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    logic [CMD_W-1:0]     s_command;
    logic [IDX_W-1:0]     s_reg_index;
    logic [VAL_W-1:0]     s_reg_value;
    logic                 s_sda_in;
    logic                 m_valid;
    logic                 m_ready;
    logic                 m_scl_out;
    logic                 m_sda_out;
    logic                 m_busy_res;
    logic                 m_done_res;
    logic [STAT_W-1:0]    m_status;
    logic [VAL_W-1:0]     m_read_data;

    // Sequencer model state
    bus_phase_t           bus_ph;
    logic [PT_W-1:0]      ph_timer;
    logic [BITC_W-1:0]    bits_sent;
    logic [BYTEC_W-1:0]   bytes_acked;
    logic [7:0]           out_byte;
    logic [IDX_W-1:0]     xfer_idx;
    logic [VAL_W-1:0]     xfer_val;
    status_t              xfer_status;
    logic [VAL_W-1:0]     shadow [SHADOW_DEPTH];
    logic [PT_W-1:0]      cur_phase_ticks;
    logic [DEV_W-1:0]     cur_dev_addr;

    bus_tick_t            tick_q[$];
    bus_tick_t            want;
    int                   mismatches;
    int                   words_sent;
    int                   results_seen;
    int                   xfers_ok;
    int                   addr_nacks;
    int                   data_nacks;
    int                   src_idle_pct;
    int                   sink_stall_pct;
    int                   quiet_cycles;
    logic [IDX_W-1:0]     recent_idx;

    i2c_codec_register_writer u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_command   (s_command),
        .s_reg_index (s_reg_index),
        .s_reg_value (s_reg_value),
        .s_sda_in    (s_sda_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_scl_out   (m_scl_out),
        .m_sda_out   (m_sda_out),
        .m_busy_res  (m_busy_res),
        .m_done_res  (m_done_res),
        .m_status    (m_status),
        .m_read_data (m_read_data)
    );

    always #1 aclk = ~aclk;

    // Load reset state into the sequencer model
    task automatic reset_model();
        bus_ph          = PH_IDLE;
        ph_timer        = '0;
        bits_sent       = '0;
        bytes_acked     = '0;
        out_byte        = '0;
        xfer_idx        = '0;
        xfer_val        = '0;
        xfer_status     = STAT_OK;
        cur_phase_ticks = PHASE_TICKS_RESET;
        cur_dev_addr    = DEV_ADDR_RESET;
        for (int i = 0; i < SHADOW_DEPTH; i++)
            shadow[i] = CODEC_DEFAULTS[i];
    endtask

    // Advance the sequencer model by one tick and return its result word
    function automatic bus_tick_t advance_bus(input logic [CMD_W-1:0] cmd,
                                              input logic [IDX_W-1:0] idx,
                                              input logic [VAL_W-1:0] val,
                                              input logic             sda_in);
        bus_tick_t   r;
        bus_phase_t  ph;
        logic [16:0] span;
        r     = '0;
        r.scl = 1'b1;
        r.sda = 1'b1;
        span  = (cur_phase_ticks == '0) ? 17'd1 : {1'b0, cur_phase_ticks};

        // serve reads from the shadow as it stands before this tick
        if (cmd == CMD_READ && idx < SHADOW_DEPTH)
            r.rdata = shadow[idx];

        // start a transfer only from idle
        if (bus_ph == PH_IDLE && cmd == CMD_WRITE) begin
            xfer_idx    = idx;
            xfer_val    = val;
            out_byte    = cur_dev_addr;
            bits_sent   = '0;
            bytes_acked = '0;
            xfer_status = STAT_OK;
            ph_timer    = '0;
            bus_ph      = PH_START_A;
        end

        ph = bus_ph;
        if (ph != PH_IDLE) begin
            r.busy = 1'b1;
            case (ph)
                PH_START_A: ;
                PH_START_B: r.sda = 1'b0;
                PH_START_C: begin
                    r.scl = 1'b0;
                    r.sda = 1'b0;
                end
                PH_BIT_0, PH_BIT_1, PH_BIT_2, PH_BIT_3: begin
                    r.scl = (ph >= PH_BIT_2);
                    r.sda = out_byte[7];
                end
                PH_ACK_0, PH_ACK_1, PH_ACK_2, PH_ACK_3: r.scl = (ph >= PH_ACK_2);
                PH_STOP_A: begin
                    r.scl = 1'b0;
                    r.sda = 1'b0;
                end
                PH_STOP_B: r.sda = 1'b0;
                default: ;
            endcase

            // hold the phase until its tick count runs out
            if ({1'b0, ph_timer} + 17'd1 < span) begin
                ph_timer = ph_timer + 1'b1;
            end else begin
                ph_timer = '0;
                case (ph)
                    PH_BIT_3: begin
                        out_byte  = out_byte << 1;
                        bits_sent = bits_sent + 1'b1;
                        bus_ph    = (bits_sent >= BITS_PER_BYTE) ? PH_ACK_0 : PH_BIT_0;
                    end
                    PH_ACK_3: begin
                        if (sda_in) begin
                            xfer_status = (bytes_acked == '0) ? STAT_ADDR_NACK
                                                              : STAT_DATA_NACK;
                            bus_ph = PH_STOP_A;
                        end else begin
                            bytes_acked = bytes_acked + 1'b1;
                            bits_sent   = '0;
                            if (bytes_acked == 2'd1) begin
                                out_byte = {1'b0, xfer_idx, xfer_val[8]};
                                bus_ph   = PH_BIT_0;
                            end else if (bytes_acked == 2'd2) begin
                                out_byte = xfer_val[7:0];
                                bus_ph   = PH_BIT_0;
                            end else begin
                                bus_ph = PH_STOP_A;
                            end
                        end
                    end
                    PH_STOP_C: begin
                        if (xfer_status == STAT_OK && xfer_idx < SHADOW_DEPTH)
                            shadow[xfer_idx] = xfer_val;
                        case (xfer_status)
                            STAT_OK:        xfers_ok++;
                            STAT_ADDR_NACK: addr_nacks++;
                            default:        data_nacks++;
                        endcase
                        r.done = 1'b1;
                        bus_ph = PH_IDLE;
                    end
                    default: bus_ph = bus_phase_t'(ph + 1);
                endcase
            end
        end
        r.status = xfer_status;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int exp);
        if (mismatches < PRINT_LIMIT)
            $display("mismatch on result %0d: %s got 0x%0h, expected 0x%0h",
                     results_seen, field, got, exp);
        mismatches++;
    endtask

    // Send one tick word and queue its predicted result
    task automatic send_tick(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                             input logic [VAL_W-1:0] val, input logic sda_in);
        @(negedge aclk);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_command   <= cmd;
        s_reg_index <= idx;
        s_reg_value <= val;
        s_sda_in    <= sda_in;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tick_q.push_back(advance_bus(cmd, idx, val, sda_in));
        words_sent++;
    endtask

    // Drop valid and wait until every expected word has come back
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (tick_q.size() != 0) @(posedge aclk);
    endtask

    task automatic write_register(input cfg_reg_t idx, input logic [PT_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == CFG_PHASE_TICKS)
            cur_phase_ticks = data;
        else
            cur_dev_addr = data[DEV_W-1:0];
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Reset-table reads at both ends and past the table, unused command code
    task automatic test_default_reads();
        send_tick(CMD_READ, 6'd0, 9'd0, 1'b0);
        send_tick(CMD_READ, 6'd8, 9'h1FF, 1'b1);
        send_tick(CMD_READ, 6'(SHADOW_DEPTH - 1), 9'd0, 1'b0);
        send_tick(CMD_READ, 6'(SHADOW_DEPTH), 9'd0, 1'b0);
        send_tick(CMD_READ, 6'd63, 9'h1FF, 1'b1);
        send_tick(CMD_UNUSED, 6'd63, 9'h1FF, 1'b1);
        send_tick(CMD_TICK, 6'd0, 9'd0, 1'b0);
    endtask

    // Start a transfer to an index past the table, then try to write again
    task automatic test_busy_writes();
        send_tick(CMD_WRITE, 6'd63, 9'h1FF, 1'b0);
        send_tick(CMD_WRITE, 6'd0, 9'd0, 1'b0);
        send_tick(CMD_READ, 6'd0, 9'd0, 1'b0);
        send_tick(CMD_WRITE, 6'd5, 9'h0AA, 1'b1);
        send_tick(CMD_TICK, 6'd0, 9'd0, 1'b0);
    endtask

    // Stretch phases to the maximum, then cut them short mid-phase
    task automatic test_phase_stretch();
        wait_drained();
        write_register(CFG_PHASE_TICKS, 16'hFFFF);
        repeat (4) send_tick(CMD_TICK, 6'd0, 9'd0, 1'b0);
        wait_drained();
        write_register(CFG_PHASE_TICKS, 16'd1);
        repeat (4) send_tick(CMD_READ, 6'd1, 9'd0, 1'b0);
        wait_drained();
    endtask

    // Random ticks: frequent writes so transfers restart soon after idle,
    // reads aimed at recently written registers, and random ACK levels
    task automatic test_random_traffic(input int n, input int src_pct, input int sink_pct,
                                       input logic [PT_W-1:0] ticks,
                                       input logic [DEV_W-1:0] dev);
        int               pick;
        logic [CMD_W-1:0] cmd;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] val;
        logic             sda;
        wait_drained();
        write_register(CFG_PHASE_TICKS, ticks);
        write_register(CFG_DEV_ADDR, {{(PT_W-DEV_W){1'b0}}, dev});
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            val  = VAL_W'($urandom_range(511));
            sda  = ($urandom_range(99) < 20);
            if (pick < 35) begin
                cmd = CMD_WRITE;
                idx = ($urandom_range(99) < 85) ? IDX_W'($urandom_range(SHADOW_DEPTH - 1))
                                                : IDX_W'($urandom_range(63, SHADOW_DEPTH));
                if (bus_ph == PH_IDLE)
                    recent_idx = idx;
            end else if (pick < 65) begin
                cmd = CMD_READ;
                idx = ($urandom_range(99) < 40) ? recent_idx : IDX_W'($urandom_range(63));
            end else if (pick < 92) begin
                cmd = CMD_TICK;
                idx = IDX_W'($urandom_range(63));
            end else begin
                cmd = CMD_UNUSED;
                idx = IDX_W'($urandom_range(63));
            end
            send_tick(cmd, idx, val, sda);
        end
        wait_drained();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
    endtask

    // Drive result-side backpressure
    always @(negedge aclk) begin
        m_ready <= (sink_stall_pct == 0) || ($urandom_range(99) >= sink_stall_pct);
    end

    // Compare each result word with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (tick_q.size() == 0) begin
                report_mismatch("unexpected word", m_status, 0);
            end else begin
                want = tick_q.pop_front();
                if (m_scl_out !== want.scl)
                    report_mismatch("scl_out", m_scl_out, want.scl);
                if (m_sda_out !== want.sda)
                    report_mismatch("sda_out", m_sda_out, want.sda);
                if (m_busy_res !== want.busy)
                    report_mismatch("busy_res", m_busy_res, want.busy);
                if (m_done_res !== want.done)
                    report_mismatch("done_res", m_done_res, want.done);
                if (m_status !== want.status)
                    report_mismatch("status", m_status, want.status);
                if (m_read_data !== want.rdata)
                    report_mismatch("read_data", m_read_data, want.rdata);
            end
            results_seen++;
        end
    end

    // Abort when no word moves on any channel for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        aresetn        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_PHASE_TICKS;
        cfg_data       = '0;
        s_valid        = 1'b0;
        s_command      = CMD_TICK;
        s_reg_index    = '0;
        s_reg_value    = '0;
        s_sda_in       = 1'b0;
        m_ready        = 1'b1;
        mismatches     = 0;
        words_sent     = 0;
        results_seen   = 0;
        xfers_ok       = 0;
        addr_nacks     = 0;
        data_nacks     = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        quiet_cycles   = 0;
        recent_idx     = '0;
        reset_model();

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_default_reads();
        test_busy_writes();
        test_phase_stretch();
        test_random_traffic(95, 0, 0, 16'd0, 8'hFF);
        test_random_traffic(95, 47, 0, 16'd1, 8'h00);
        test_random_traffic(95, 0, 47, 16'd2, 8'($urandom_range(255)));
        test_random_traffic(95, 28, 28, 16'd1, DEV_ADDR_RESET);

        wait_drained();
        repeat (8) @(posedge aclk);

        $display("sent %0d tick words, checked %0d results, %0d mismatches",
                 words_sent, results_seen, mismatches);
        $display("transfers finished: %0d acknowledged, %0d address NACK, %0d data NACK",
                 xfers_ok, addr_nacks, data_nacks);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
